/* src/spt_pkg.sv */
// ----------------------------------------------------------------------------
// spt_pkg: shared types and constants of the SPT scheduler with rejection
// Holds the request and result payload structs, the result kind codes and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package spt_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned VAL_W   = 10;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned COMP_W  = 21;
    localparam int unsigned REJ_W   = 16;
    localparam int unsigned OBJ_W   = 22;
    localparam int unsigned RUN_W   = 16;

    // Configuration register indexes.
    localparam logic CFG_MIN_VALUE = 1'b0;
    localparam logic CFG_MAX_VALUE = 1'b1;

    // Configuration reset values.
    localparam logic [VAL_W-1:0] MIN_VALUE_RST = 10'd1;
    localparam logic [VAL_W-1:0] MAX_VALUE_RST = 10'd1000;

    // Result kind codes.
    localparam logic [KIND_W-1:0] KIND_JOB     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TOTALS  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INVALID = 2'd2;

    // One input request.
    typedef struct packed {
        logic [VAL_W-1:0] job_time;
        logic [VAL_W-1:0] reject_cost;
        logic             accepted;
        logic             last_job;
    } t_in_item;

    // One result.
    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [VAL_W-1:0]  out_time;
        logic [VAL_W-1:0]  out_cost;
        logic [COMP_W-1:0] total_completion;
        logic [REJ_W-1:0]  total_rejection;
        logic [OBJ_W-1:0]  objective;
        logic              last_result;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // take the input request and update the counters
        logic rd_prev;     // read the entry just below the insert position
        logic shift;       // move the read entry up one slot, read the next one
        logic wr_new;      // write the new job at the insert position
        logic emit_start;  // clear the emission index and running sums
        logic acc_comp;    // add the running time into the completion sum
        logic rd_emit;     // read the entry at the emission index
        logic out_job;     // load a sorted job result
        logic out_inv;     // load the invalid result and clear the instance
        logic out_tot;     // load the totals result and clear the instance
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic store;      // the last accepted request goes into the job store
        logic last;       // the last accepted request closes the instance
        logic invalid;    // the instance has failed a check
        logic pos_zero;   // insert position is the bottom slot
        logic pos_one;    // insert position is one above the bottom slot
        logic prev_gt;    // read entry has a longer time than the new job
        logic emit_done;  // every stored job has been emitted
        logic out_free;   // the output register can take a result this cycle
    } t_dp_status;

endpackage

/* src/spt_schedule_with_rejection_core.sv */
// ----------------------------------------------------------------------------
// spt_schedule_with_rejection_core: SPT scheduling with job rejection
// Collects the jobs of one run, keeps the accepted ones sorted by time and
// reports them shortest first with the run totals, or flags an invalid run.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. A rejected job, one that arrives after
// MAX_JOBS jobs, or an accepted job that goes into an empty store needs no
// walk; any other accepted job is placed by walking the sorted store one
// entry per cycle through its single read port, moving every stored job
// with a longer time up one slot. A request marked last_job then produces
// its results from that store: each sorted job is read through the
// registered store read and loaded into the output register when it is free,
// then the totals follow, or one invalid result if any time or cost fell
// outside the bounds or too many jobs arrived. A new request is taken as
// soon as the final result has been loaded, even while it is still stalled.
module spt_schedule_with_rejection_core #(
    parameter int unsigned MAX_JOBS = 63
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [9:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  spt_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output spt_pkg::t_out_item o_out_item
);

    spt_pkg::t_dp_cmd    dp_cmd;
    spt_pkg::t_dp_status dp_status;

    // Sequencing controller.
    spt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd),
        .i_status   (dp_status)
    );

    // Counters, job store and output register.
    spt_dp #(
        .MAX_JOBS (MAX_JOBS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status)
    );

endmodule

/* src/spt_ctrl.sv */
// ----------------------------------------------------------------------------
// spt_ctrl: sequencing controller of the SPT scheduler
// Accepts one request at a time, steps the insertion of accepted jobs into
// the sorted store and steps the emission of results at the end of a run.
// ----------------------------------------------------------------------------
module spt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output spt_pkg::t_dp_cmd    o_cmd,
    input  spt_pkg::t_dp_status i_status
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DECIDE   = 4'd1;
    localparam logic [3:0] ST_CMP      = 4'd2;
    localparam logic [3:0] ST_PUT      = 4'd3;
    localparam logic [3:0] ST_AFTER    = 4'd4;
    localparam logic [3:0] ST_EMIT_INV = 4'd5;
    localparam logic [3:0] ST_EMIT_RD  = 4'd6;
    localparam logic [3:0] ST_EMIT_OUT = 4'd7;
    localparam logic [3:0] ST_TOT      = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Requests are taken only while no job is being placed or emitted.
    assign o_in_stall = (r_state != ST_IDLE);

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (i_status.store) begin
                    if (i_status.pos_zero) begin
                        o_cmd.wr_new = 1'b1;
                        n_state      = ST_AFTER;
                    end else begin
                        o_cmd.rd_prev = 1'b1;
                        n_state       = ST_CMP;
                    end
                end else begin
                    n_state = ST_AFTER;
                end
            end
            ST_CMP: begin
                // Longer jobs move up; an equal time stops the walk, which
                // keeps the order of arrival among equal times.
                if (i_status.prev_gt) begin
                    o_cmd.shift = 1'b1;
                    if (i_status.pos_one) begin
                        n_state = ST_PUT;
                    end
                end else begin
                    o_cmd.wr_new = 1'b1;
                    n_state      = ST_AFTER;
                end
            end
            ST_PUT: begin
                o_cmd.wr_new = 1'b1;
                n_state      = ST_AFTER;
            end
            ST_AFTER: begin
                if (!i_status.last) begin
                    n_state = ST_IDLE;
                end else if (i_status.invalid) begin
                    n_state = ST_EMIT_INV;
                end else begin
                    o_cmd.emit_start = 1'b1;
                    n_state          = ST_EMIT_RD;
                end
            end
            ST_EMIT_INV: begin
                if (i_status.out_free) begin
                    o_cmd.out_inv = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                o_cmd.acc_comp = 1'b1;
                if (i_status.emit_done) begin
                    n_state = ST_TOT;
                end else begin
                    o_cmd.rd_emit = 1'b1;
                    n_state       = ST_EMIT_OUT;
                end
            end
            ST_EMIT_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_job = 1'b1;
                    n_state       = ST_EMIT_RD;
                end
            end
            ST_TOT: begin
                if (i_status.out_free) begin
                    o_cmd.out_tot = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/spt_dp.sv */
// ----------------------------------------------------------------------------
// spt_dp: datapath of the SPT scheduler
// Holds the bounds, the instance counters, the sorted job store with its
// registered read port, the completion sums and the output register.
// ----------------------------------------------------------------------------
module spt_dp #(
    parameter int unsigned MAX_JOBS = 63
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [9:0]          i_cfg_data,
    input  spt_pkg::t_in_item   i_in_item,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output spt_pkg::t_out_item  o_out_item,
    input  spt_pkg::t_dp_cmd    i_cmd,
    output spt_pkg::t_dp_status o_status
);

    localparam int unsigned IDX_W = $clog2(MAX_JOBS);
    localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);
    localparam int unsigned ENT_W = 2 * spt_pkg::VAL_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_JOBS);

    // Bounds.
    logic [spt_pkg::VAL_W-1:0] r_min;
    logic [spt_pkg::VAL_W-1:0] r_max;

    // Instance state.
    logic [CNT_W-1:0]          r_job_cnt;
    logic [CNT_W-1:0]          r_acc_cnt;
    logic [spt_pkg::REJ_W-1:0] r_rej_sum;
    logic                      r_invalid;
    logic                      r_store;
    logic                      r_last;
    logic [spt_pkg::VAL_W-1:0] r_new_time;
    logic [spt_pkg::VAL_W-1:0] r_new_cost;
    logic [IDX_W-1:0]          r_pos;

    // Job store, one entry of time and cost per sorted job.
    logic [ENT_W-1:0]          r_mem [MAX_JOBS];
    logic [ENT_W-1:0]          r_rd_data;

    // Emission.
    logic [CNT_W-1:0]          r_emit_idx;
    logic [spt_pkg::RUN_W-1:0] r_run;
    logic [spt_pkg::COMP_W-1:0] r_comp;
    logic                      r_out_valid;
    spt_pkg::t_out_item        r_out;
    spt_pkg::t_out_item        n_out;

    logic                      out_of_range;
    logic                      wr_en;
    logic [ENT_W-1:0]          wr_data;
    logic                      rd_en;
    logic [IDX_W-1:0]          rd_addr;
    logic                      out_free;
    logic                      inst_clear;
    logic [spt_pkg::VAL_W-1:0] rd_time;

    assign rd_time    = r_rd_data[ENT_W-1:spt_pkg::VAL_W];
    assign out_free   = !r_out_valid || !i_out_stall;
    assign inst_clear = i_cmd.out_inv || i_cmd.out_tot;

    // Range check of the incoming request against the bounds.
    assign out_of_range = (i_in_item.job_time < r_min) || (i_in_item.job_time > r_max)
                       || (i_in_item.reject_cost < r_min)
                       || (i_in_item.reject_cost > r_max);

    // Store port selection: a shift moves the read entry up, otherwise the
    // new job lands at the insert position.
    assign wr_en   = i_cmd.shift || i_cmd.wr_new;
    assign wr_data = i_cmd.shift ? r_rd_data : {r_new_time, r_new_cost};
    assign rd_en   = i_cmd.rd_prev || i_cmd.shift || i_cmd.rd_emit;

    always_comb begin
        if (i_cmd.rd_emit) begin
            rd_addr = r_emit_idx[IDX_W-1:0];
        end else if (i_cmd.shift) begin
            rd_addr = r_pos - IDX_W'(2);
        end else begin
            rd_addr = r_pos - IDX_W'(1);
        end
    end

    // Job store with registered read data.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_pos] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= spt_pkg::MIN_VALUE_RST;
            r_max <= spt_pkg::MAX_VALUE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                spt_pkg::CFG_MIN_VALUE: r_min <= i_cfg_data;
                spt_pkg::CFG_MAX_VALUE: r_max <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Instance counters, checks and the rejection sum.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_cnt <= '0;
            r_acc_cnt <= '0;
            r_rej_sum <= '0;
            r_invalid <= 1'b0;
            r_store   <= 1'b0;
            r_last    <= 1'b0;
        end else if (inst_clear) begin
            r_job_cnt <= '0;
            r_acc_cnt <= '0;
            r_rej_sum <= '0;
            r_invalid <= 1'b0;
        end else if (i_cmd.accept) begin
            r_last  <= i_in_item.last_job;
            r_store <= 1'b0;
            if (r_job_cnt >= MAX_CNT) begin
                r_invalid <= 1'b1;
            end else begin
                r_job_cnt <= r_job_cnt + CNT_W'(1);
                if (out_of_range) begin
                    r_invalid <= 1'b1;
                end
                if (i_in_item.accepted) begin
                    r_store   <= 1'b1;
                    r_acc_cnt <= r_acc_cnt + CNT_W'(1);
                end else begin
                    r_rej_sum <= r_rej_sum + spt_pkg::REJ_W'(i_in_item.reject_cost);
                end
            end
        end
    end

    // New job and its insert position, which walks down on each shift.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_new_time <= i_in_item.job_time;
            r_new_cost <= i_in_item.reject_cost;
            r_pos      <= r_acc_cnt[IDX_W-1:0];
        end else if (i_cmd.shift) begin
            r_pos <= r_pos - IDX_W'(1);
        end
    end

    // Emission index and completion sums. The running time is folded into
    // the completion sum once per visit of the read step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_start) begin
            r_emit_idx <= '0;
            r_run      <= '0;
            r_comp     <= '0;
        end else begin
            if (i_cmd.acc_comp) begin
                r_comp <= r_comp + spt_pkg::COMP_W'(r_run);
            end
            if (i_cmd.out_job) begin
                r_emit_idx <= r_emit_idx + CNT_W'(1);
                r_run      <= r_run + spt_pkg::RUN_W'(rd_time);
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_job || i_cmd.out_inv || i_cmd.out_tot) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result to be loaded: unused fields stay zero.
    always_comb begin
        n_out = '0;
        if (i_cmd.out_job) begin
            n_out.result_kind = spt_pkg::KIND_JOB;
            n_out.out_time    = rd_time;
            n_out.out_cost    = r_rd_data[spt_pkg::VAL_W-1:0];
        end else if (i_cmd.out_inv) begin
            n_out.result_kind = spt_pkg::KIND_INVALID;
            n_out.last_result = 1'b1;
        end else if (i_cmd.out_tot) begin
            n_out.result_kind      = spt_pkg::KIND_TOTALS;
            n_out.total_completion = r_comp;
            n_out.total_rejection  = r_rej_sum;
            n_out.objective        = spt_pkg::OBJ_W'(r_comp)
                                   + spt_pkg::OBJ_W'(r_rej_sum);
            n_out.last_result      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_job || i_cmd.out_inv || i_cmd.out_tot) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Status to the controller.
    assign o_status.store     = r_store;
    assign o_status.last      = r_last;
    assign o_status.invalid   = r_invalid;
    assign o_status.pos_zero  = (r_pos == '0);
    assign o_status.pos_one   = (r_pos == IDX_W'(1));
    assign o_status.prev_gt   = (rd_time > r_new_time);
    assign o_status.emit_done = (r_emit_idx == r_acc_cnt);
    assign o_status.out_free  = out_free;

endmodule
